// ===== hw/rtl/bpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, sizes and sequencer states shared by the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES   = 1024;
	localparam int POOL_W  = 37;
	localparam int PAGE_W  = 21;
	localparam int LEN_W   = 32;
	localparam int IDX_W   = 10;
	localparam int IW      = $clog2(PAGES);
	localparam int PCW     = $clog2(PAGES + 1);
	localparam int ORD_W   = $clog2(IW + 1);
	localparam int BUD_W   = 2 ** ORD_W;
	localparam int CUR_W   = BUD_W + 1;
	localparam int CIDX_W  = 2;
	localparam int MIN_PAGE_LSB = 7;

	localparam logic [POOL_W-1:0] POOL_RST = POOL_W'(4194304);
	localparam logic [PAGE_W-1:0] PAGE_RST = PAGE_W'(4096);

	localparam logic [CIDX_W-1:0] REG_POOL = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_PAGE = CIDX_W'(1);

	localparam logic [1:0] OP_REBUILD = 2'd0;
	localparam logic [1:0] OP_ALLOC   = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [LEN_W-1:0] length_bytes;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] granted_index;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_CHK,
		ST_DIV,
		ST_TOP,
		ST_HEAD,
		ST_SIZE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_SPLIT,
		ST_TAKE,
		ST_FREE0,
		ST_FREE_ORD,
		ST_FREE_BUD,
		ST_FREE_CMP,
		ST_FREE_MRG,
		ST_DONE
	} state_t;

	// bits needed to hold v
	function automatic logic [ORD_W-1:0] bit_len(input logic [PCW-1:0] v);
		logic [ORD_W-1:0] r;
		r = '0;
		for (int i = 0; i < PCW; i++) begin
			if (v[i]) r = ORD_W'(i + 1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/buddy_page_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator: one taken flag and one order per page, a sequencer
// around a shared shift/compare/subtract unit, and two table RAMs.
// ----------------------------------------------------------------------------
// Steps: free marks the block free, reads its order, then checks its buddy and
//   merges while the buddy is free and of the same order; alloc sizes the
//   request, scans the block heads for the best fit, splits it and takes it.
// Rebuild: clear tables, check config, divide pool by page size, write heads.
// Throughput: one transfer at a time; in_stall is high while busy, set by the
//   sequential table scan through the single read port of each RAM.
// Reset: asynchronous, control registers to defaults, then a clearing pass
//   and a quiet rebuild (no result) before the first input is taken.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire bpa_pkg::req_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output bpa_pkg::rsp_t                       out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bpa_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [bpa_pkg::POOL_W-1:0]     cfg_data
);
	import bpa_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [POOL_W-1:0] pool_q;
	logic [PAGE_W-1:0] page_q;

	// pool state
	logic [PCW-1:0]   pc_q;
	logic [ORD_W-1:0] top_q;
	logic             ready_q;

	// work registers
	req_t             req_q;
	logic             quiet_q;
	logic [IW-1:0]    cnt_q;      // clear sweep address
	logic [POOL_W-1:0] rem_q;
	logic [IW-1:0]    quo_q;
	logic [ORD_W-1:0] bit_q;      // divide bit / head bit / size order
	logic [PCW-1:0]   hidx_q;
	logic [ORD_W-1:0] want_q;
	logic [CUR_W-1:0] curr_q;
	logic             found_q;
	logic [IW-1:0]    best_q;
	logic [ORD_W-1:0] bord_q;     // order of best / current free block
	logic [BUD_W-1:0] buddy_q;
	logic             res_fail_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic in_xfer, out_load;

	// RAM ports
	logic             ord_we, tk_we;
	logic [IW-1:0]    ord_wa, tk_wa, rd_a;
	logic [ORD_W-1:0] ord_wd, ord_rd;
	logic             tk_wd, tk_rd;

	// shared unit
	logic [POOL_W-1:0] u_a, u_b, u_diff;
	logic [ORD_W-1:0]  u_sh;
	logic              u_ge, u_eq;

	// derived per state
	logic [CUR_W-1:0] pc_c;
	logic [BUD_W-1:0] pc_b;
	logic             pb_bad;
	logic [IW-1:0]    quo_d;
	logic [ORD_W-1:0] split_ord;
	logic [BUD_W-1:0] split_bud;
	logic [BUD_W-1:0] free_bud;
	logic             fits;

	assign pc_c      = CUR_W'(pc_q);
	assign pc_b      = BUD_W'(pc_q);
	assign pb_bad    = (page_q == '0) || (page_q[MIN_PAGE_LSB-1:0] != '0);
	assign quo_d     = quo_q | (u_ge ? (IW'(1) << bit_q) : '0);
	assign split_ord = bord_q - ORD_W'(1);
	assign split_bud = BUD_W'(best_q) ^ (BUD_W'(1) << split_ord);
	assign free_bud  = BUD_W'(curr_q) ^ (BUD_W'(1) << bord_q);
	assign fits      = !u_ge || u_eq;    // length <= page_bytes << order

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_DONE) && !quiet_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bpa_ram #(.W(ORD_W), .D(PAGES)) u_ord (
		.clk  (clk),
		.we   (ord_we),
		.waddr(ord_wa),
		.wdata(ord_wd),
		.raddr(rd_a),
		.rdata(ord_rd)
	);

	bpa_ram #(.W(1), .D(PAGES)) u_tk (
		.clk  (clk),
		.we   (tk_we),
		.waddr(tk_wa),
		.wdata(tk_wd),
		.raddr(rd_a),
		.rdata(tk_rd)
	);

	bpa_cmp u_cmp (
		.a   (u_a),
		.b   (u_b),
		.sh  (u_sh),
		.ge  (u_ge),
		.eq  (u_eq),
		.diff(u_diff)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (in_data.opcode)
						OP_REBUILD: state_d = ST_CLR;
						OP_ALLOC:   state_d = ST_SIZE;
						OP_FREE:    state_d = ST_FREE0;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_CLR:  if (cnt_q == IW'(PAGES - 1)) state_d = ST_CHK;
			ST_CHK: begin
				if (pb_bad)    state_d = ST_DONE;
				else if (u_ge) state_d = ST_TOP;
				else           state_d = ST_DIV;
			end
			ST_DIV: begin
				if (bit_q == '0) state_d = (quo_d == '0) ? ST_DONE : ST_TOP;
			end
			ST_TOP:  state_d = ST_HEAD;
			ST_HEAD: if (bit_q == '0) state_d = ST_DONE;
			ST_SIZE: begin
				if (!ready_q || req_q.length_bytes == '0) state_d = ST_DONE;
				else if (fits)                            state_d = ST_SCAN_RD;
				else if (bit_q == top_q)                  state_d = ST_DONE;
			end
			ST_SCAN_RD: begin
				if (curr_q >= pc_c) state_d = found_q ? ST_SPLIT : ST_DONE;
				else                state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				if (!tk_rd && ord_rd == want_q) state_d = ST_TAKE;
				else                            state_d = ST_SCAN_RD;
			end
			ST_SPLIT: if (split_ord == want_q) state_d = ST_TAKE;
			ST_TAKE:  state_d = ST_DONE;
			ST_FREE0: begin
				if (!ready_q || PCW'(req_q.block_index) >= pc_q) state_d = ST_DONE;
				else                                             state_d = ST_FREE_ORD;
			end
			ST_FREE_ORD: state_d = ST_FREE_BUD;
			ST_FREE_BUD: state_d = (free_bud >= pc_b) ? ST_DONE : ST_FREE_CMP;
			ST_FREE_CMP: state_d = (tk_rd || ord_rd != bord_q) ? ST_DONE : ST_FREE_MRG;
			ST_FREE_MRG: state_d = ST_FREE_BUD;
			ST_DONE:     if (quiet_q || out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM and shared unit controls
	always_comb begin
		ord_we = 1'b0;
		ord_wa = '0;
		ord_wd = '0;
		tk_we  = 1'b0;
		tk_wa  = '0;
		tk_wd  = 1'b0;
		rd_a   = curr_q[IW-1:0];
		u_a    = rem_q;
		u_b    = POOL_W'(page_q);
		u_sh   = bit_q;
		case (state_q)
			ST_CLR: begin
				ord_we = 1'b1;
				ord_wa = cnt_q;
				tk_we  = 1'b1;
				tk_wa  = cnt_q;
			end
			ST_CHK: begin
				u_a  = pool_q;
				u_b  = POOL_W'(page_q) * POOL_W'(PAGES);
				u_sh = '0;
			end
			ST_HEAD: begin
				ord_we = pc_q[bit_q[$clog2(PCW)-1:0]] && (hidx_q < PCW'(PAGES));
				ord_wa = hidx_q[IW-1:0];
				ord_wd = bit_q;
			end
			ST_SIZE: begin
				u_a = POOL_W'(req_q.length_bytes);
			end
			ST_SPLIT: begin
				ord_we = (split_bud < pc_b);
				ord_wa = split_bud[IW-1:0];
				ord_wd = split_ord;
			end
			ST_TAKE: begin
				ord_we = 1'b1;
				ord_wa = best_q;
				ord_wd = want_q;
				tk_we  = 1'b1;
				tk_wa  = best_q;
				tk_wd  = 1'b1;
			end
			ST_FREE0: begin
				tk_we = ready_q && (PCW'(req_q.block_index) < pc_q);
				tk_wa = req_q.block_index[IW-1:0];
				rd_a  = req_q.block_index[IW-1:0];
			end
			ST_FREE_BUD: begin
				rd_a = free_bud[IW-1:0];
			end
			ST_FREE_CMP: begin
				ord_we = !tk_rd && (ord_rd == bord_q);
				ord_wa = buddy_q[IW-1:0];
				ord_wd = bord_q + ORD_W'(1);
			end
			ST_FREE_MRG: begin
				ord_we = 1'b1;
				ord_wa = curr_q[IW-1:0];
				ord_wd = bord_q + ORD_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			quiet_q     <= 1'b1;
			cnt_q       <= '0;
			pool_q      <= POOL_RST;
			page_q      <= PAGE_RST;
			pc_q        <= PCW'(PAGES);
			top_q       <= bit_len(PCW'(PAGES - 1));
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POOL) pool_q <= cfg_data;
				if (cfg_index == REG_PAGE) page_q <= cfg_data[PAGE_W-1:0];
			end
			if (out_load)                     out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (in_xfer) begin
				quiet_q <= 1'b0;
				cnt_q   <= '0;
			end
			if (state_q == ST_CLR) cnt_q <= cnt_q + IW'(1);
			if (state_q == ST_CHK) begin
				ready_q <= 1'b0;
				pc_q    <= '0;
				top_q   <= '0;
				if (!pb_bad && u_ge) pc_q <= PCW'(PAGES);
			end
			if (state_q == ST_DIV && bit_q == '0) pc_q <= PCW'(quo_d);
			if (state_q == ST_TOP) begin
				top_q   <= bit_len(pc_q - PCW'(1));
				ready_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status        <= res_fail_q;
			out_q.granted_index <= res_fail_q ? '0 : res_idx_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					req_q      <= in_data;
					res_fail_q <= 1'b1;
					res_idx_q  <= '0;
					bit_q      <= '0;
				end
			end
			ST_CHK: begin
				rem_q <= pool_q;
				quo_q <= '0;
				bit_q <= ORD_W'(IW - 1);
			end
			ST_DIV: begin
				if (u_ge) rem_q <= u_diff;
				quo_q <= quo_d;
				bit_q <= bit_q - ORD_W'(1);
			end
			ST_TOP: begin
				hidx_q <= '0;
				bit_q  <= ORD_W'(PCW - 1);
			end
			ST_HEAD: begin
				if (pc_q[bit_q[$clog2(PCW)-1:0]]) hidx_q <= hidx_q + (PCW'(1) << bit_q);
				bit_q <= bit_q - ORD_W'(1);
				if (bit_q == '0) res_fail_q <= 1'b0;
			end
			ST_SIZE: begin
				want_q  <= bit_q;
				curr_q  <= '0;
				found_q <= 1'b0;
				bit_q   <= bit_q + ORD_W'(1);
			end
			ST_SCAN_EV: begin
				if (!tk_rd && (ord_rd == want_q ||
				    (ord_rd > want_q && (!found_q || ord_rd < bord_q)))) begin
					best_q  <= curr_q[IW-1:0];
					bord_q  <= ord_rd;
					found_q <= 1'b1;
				end
				curr_q <= curr_q + (CUR_W'(1) << ord_rd);
			end
			ST_SPLIT: bord_q <= split_ord;
			ST_TAKE: begin
				res_fail_q <= 1'b0;
				res_idx_q  <= IDX_W'(best_q);
			end
			ST_FREE0: begin
				curr_q <= CUR_W'(req_q.block_index);
				if (ready_q && PCW'(req_q.block_index) < pc_q) res_fail_q <= 1'b0;
			end
			ST_FREE_ORD: bord_q  <= ord_rd;
			ST_FREE_BUD: buddy_q <= free_bud;
			ST_FREE_MRG: begin
				bord_q <= bord_q + ORD_W'(1);
				if (CUR_W'(buddy_q) < curr_q) curr_q <= CUR_W'(buddy_q);
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int W  = 4,
	parameter int D  = 1024,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bpa_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_cmp
// Shared shift, compare and subtract unit: a against b shifted left by sh.
// ----------------------------------------------------------------------------
module bpa_cmp (
	input  wire logic [bpa_pkg::POOL_W-1:0] a,
	input  wire logic [bpa_pkg::POOL_W-1:0] b,
	input  wire logic [bpa_pkg::ORD_W-1:0]  sh,
	output logic                            ge,
	output logic                            eq,
	output logic      [bpa_pkg::POOL_W-1:0] diff
);
	import bpa_pkg::*;

	logic [POOL_W-1:0] bs;

	assign bs   = b << sh;
	assign ge   = (a >= bs);
	assign eq   = (a == bs);
	assign diff = a - bs;
endmodule
`default_nettype wire
